### hdl/mkde_pkg.sv
// ----------------------------------------------------------------------------
// mkde_pkg
// Shared types and constants of the keypad debounce and key encoder block.
// ----------------------------------------------------------------------------
package mkde_pkg;

  localparam int ROWS      = 4;
  localparam int COLS      = 4;
  localparam int ROW_MAX   = 4;
  localparam int COL_MAX   = 4;
  localparam int CNT_W     = 8;
  localparam int KEY_W     = 5;
  localparam int TOTAL_W   = 16;

  localparam logic [COL_MAX-1:0] COL_MASK  = COL_MAX'((1 << COLS) - 1);
  localparam logic [CNT_W-1:0]   THR_RESET = CNT_W'(5);
  localparam logic [KEY_W-1:0]   NO_KEY    = KEY_W'(16);
  localparam int                 KEY_LAST  = 15;

  typedef logic [COL_MAX-1:0] row_bits_t;
  typedef row_bits_t [ROW_MAX-1:0] row_set_t;

  typedef struct packed {
    logic [KEY_W-1:0]   current_key;
    logic [KEY_W-1:0]   last_key;
    logic               press_event;
    logic               release_event;
    logic [TOTAL_W-1:0] press_total;
  } result_t;

endpackage

### hdl/mkde_row.sv
// ----------------------------------------------------------------------------
// mkde_row
// Debounce of one keypad row: disagreement counter and debounced row word.
// ----------------------------------------------------------------------------
module mkde_row (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  mkde_pkg::row_bits_t          raw,
  input  logic [mkde_pkg::CNT_W-1:0]   thr,
  output mkde_pkg::row_bits_t          deb_nxt
);

  logic [mkde_pkg::CNT_W-1:0] cnt_r;
  logic [mkde_pkg::CNT_W-1:0] cnt_nxt;
  logic [mkde_pkg::CNT_W-1:0] cnt_inc;
  mkde_pkg::row_bits_t        deb_r;
  mkde_pkg::row_bits_t        raw_m;

  always_comb begin
    raw_m   = raw & mkde_pkg::COL_MASK;
    cnt_inc = cnt_r + mkde_pkg::CNT_W'(1);
    cnt_nxt = cnt_r;
    deb_nxt = deb_r;
    if (raw_m == deb_r) begin
      cnt_nxt = '0;
    end else if (cnt_inc >= thr) begin
      deb_nxt = raw_m;
      cnt_nxt = '0;
    end else begin
      cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      deb_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
      deb_r <= deb_nxt;
    end
  end

endmodule

### hdl/mkde_encode.sv
// ----------------------------------------------------------------------------
// mkde_encode
// Priority key encoder with press and release detection and press count.
// ----------------------------------------------------------------------------
module mkde_encode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  mkde_pkg::row_set_t  deb_rows,
  output mkde_pkg::result_t   res_nxt
);

  logic [mkde_pkg::KEY_W-1:0]   held_key_r;
  logic [mkde_pkg::KEY_W-1:0]   recent_key_r;
  logic [mkde_pkg::TOTAL_W-1:0] press_cnt_r;
  logic [mkde_pkg::KEY_W-1:0]   key;
  logic [mkde_pkg::KEY_W-1:0]   recent_nxt;
  logic [mkde_pkg::TOTAL_W-1:0] press_cnt_nxt;
  logic                         press;
  logic                         release_ev;

  // lowest index wins, so scan from the top down
  always_comb begin
    key = mkde_pkg::NO_KEY;
    for (int r = mkde_pkg::ROWS - 1; r >= 0; r--) begin
      for (int c = mkde_pkg::COLS - 1; c >= 0; c--) begin
        if (deb_rows[r][c]) begin
          if (r * mkde_pkg::COLS + c > mkde_pkg::KEY_LAST) begin
            key = mkde_pkg::NO_KEY;
          end else begin
            key = mkde_pkg::KEY_W'(r * mkde_pkg::COLS + c);
          end
        end
      end
    end
  end

  always_comb begin
    press         = (key != mkde_pkg::NO_KEY) && (held_key_r == mkde_pkg::NO_KEY);
    release_ev    = (key == mkde_pkg::NO_KEY) && (held_key_r != mkde_pkg::NO_KEY);
    recent_nxt    = press ? key : recent_key_r;
    press_cnt_nxt = press ? press_cnt_r + mkde_pkg::TOTAL_W'(1) : press_cnt_r;
    res_nxt.current_key   = key;
    res_nxt.last_key      = recent_nxt;
    res_nxt.press_event   = press;
    res_nxt.release_event = release_ev;
    res_nxt.press_total   = press_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_key_r   <= mkde_pkg::NO_KEY;
      recent_key_r <= mkde_pkg::NO_KEY;
      press_cnt_r  <= '0;
    end else if (step) begin
      held_key_r   <= key;
      recent_key_r <= recent_nxt;
      press_cnt_r  <= press_cnt_nxt;
    end
  end

endmodule

### hdl/matrix_keypad_debounce_encoder_unit.sv
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_encoder_unit
// An input transaction passes the input register and then the result register.
// Throughput: one scan per cycle while out_stall does not hold the result register.
// Reset (synchronous, active low): rows empty, counters zero, keys none,
// press count zero, debounce threshold 5.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_encoder_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [3:0]                     in_raw_row_0,
  input  logic [3:0]                     in_raw_row_1,
  input  logic [3:0]                     in_raw_row_2,
  input  logic [3:0]                     in_raw_row_3,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [4:0]                     out_current_key,
  output logic [4:0]                     out_last_key,
  output logic                           out_press_event,
  output logic                           out_release_event,
  output logic [15:0]                    out_press_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [7:0]                     cfg_debounce_scans
);

  logic [mkde_pkg::CNT_W-1:0] thr_r;
  logic                       in_vld_r;
  mkde_pkg::row_set_t         raw_r;
  mkde_pkg::row_set_t         deb_nxt;
  logic                       out_vld_r;
  mkde_pkg::result_t          res_r;
  mkde_pkg::result_t          res_nxt;
  logic                       out_free;
  logic                       step;
  logic                       in_take;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_vld_r || !out_stall;
  assign step      = in_vld_r && out_free;
  assign in_stall  = in_vld_r && !out_free;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= mkde_pkg::THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_debounce_scans;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      raw_r[0] <= in_raw_row_0;
      raw_r[1] <= in_raw_row_1;
      raw_r[2] <= in_raw_row_2;
      raw_r[3] <= in_raw_row_3;
    end
  end

  for (genvar r = 0; r < mkde_pkg::ROW_MAX; r++) begin : g_row
    if (r < mkde_pkg::ROWS) begin : g_used
      mkde_row u_row (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .raw     (raw_r[r]),
        .thr     (thr_r),
        .deb_nxt (deb_nxt[r])
      );
    end else begin : g_unused
      assign deb_nxt[r] = '0;
    end
  end

  mkde_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .deb_rows (deb_nxt),
    .res_nxt  (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_current_key   = res_r.current_key;
  assign out_last_key      = res_r.last_key;
  assign out_press_event   = res_r.press_event;
  assign out_release_event = res_r.release_event;
  assign out_press_total   = res_r.press_total;

endmodule

### tb/matrix_keypad_debounce_encoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_keypad_debounce_encoder_unit_tb
// Drives 4x4 keypad scans through the debounce and key encoder block under
// random sender gaps and receiver stalls. Each result is checked field by
// field against its listed value (typed directed scans) or an in-bench model
// of the row debounce counters, priority encoder and press/release tracking.
// Threshold register rewritten between phases, zero and maximum among them.
// ----------------------------------------------------------------------------
module matrix_keypad_debounce_encoder_unit_tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int CHUNK_SCANS    = 86;
  localparam int N_DIRECTED     = 23;

  typedef struct packed {
    logic                 is_cfg;
    logic [7:0]           thr;
    mkde_pkg::row_set_t   rows;
    logic                 typed;
    mkde_pkg::result_t    want;
  } stim_entry_t;

  // directed scans, row 3 in the top nibble
  localparam stim_entry_t DIRECTED [0:N_DIRECTED-1] = '{
    '{1'b0, 8'd0,   16'h0000, 1'b1, '{mkde_pkg::NO_KEY, mkde_pkg::NO_KEY, 1'b0, 1'b0, 16'd0}},
    '{1'b0, 8'd0,   16'hFFFF, 1'b1, '{mkde_pkg::NO_KEY, mkde_pkg::NO_KEY, 1'b0, 1'b0, 16'd0}},
    '{1'b0, 8'd0,   16'hFFFF, 1'b1, '{mkde_pkg::NO_KEY, mkde_pkg::NO_KEY, 1'b0, 1'b0, 16'd0}},
    '{1'b0, 8'd0,   16'hFFFF, 1'b1, '{mkde_pkg::NO_KEY, mkde_pkg::NO_KEY, 1'b0, 1'b0, 16'd0}},
    '{1'b0, 8'd0,   16'hFFFF, 1'b1, '{mkde_pkg::NO_KEY, mkde_pkg::NO_KEY, 1'b0, 1'b0, 16'd0}},
    '{1'b0, 8'd0,   16'hFFFF, 1'b1, '{5'd0, 5'd0, 1'b1, 1'b0, 16'd1}},
    '{1'b0, 8'd0,   16'h0000, 1'b1, '{5'd0, 5'd0, 1'b0, 1'b0, 16'd1}},
    '{1'b0, 8'd0,   16'h0000, 1'b0, '0},
    '{1'b0, 8'd0,   16'h0000, 1'b0, '0},
    // threshold lowered below a running count
    '{1'b1, 8'd2,   16'h0000, 1'b0, '0},
    '{1'b0, 8'd0,   16'h0000, 1'b1, '{mkde_pkg::NO_KEY, 5'd0, 1'b0, 1'b1, 16'd1}},
    '{1'b1, 8'd0,   16'h0000, 1'b0, '0},
    '{1'b0, 8'd0,   16'h8000, 1'b1, '{5'd15, 5'd15, 1'b1, 1'b0, 16'd2}},
    '{1'b0, 8'd0,   16'h8400, 1'b0, '0},
    '{1'b0, 8'd0,   16'h0001, 1'b0, '0},
    '{1'b0, 8'd0,   16'h0000, 1'b0, '0},
    '{1'b1, 8'd255, 16'h0000, 1'b0, '0},
    '{1'b0, 8'd0,   16'hFFFF, 1'b0, '0},
    '{1'b1, 8'd1,   16'h0000, 1'b0, '0},
    '{1'b0, 8'd0,   16'h5A3C, 1'b0, '0},
    '{1'b0, 8'd0,   16'hC3A5, 1'b0, '0},
    '{1'b0, 8'd0,   16'h0000, 1'b0, '0},
    '{1'b0, 8'd0,   16'h0000, 1'b0, '0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [3:0] in_raw_row_0 = '0;
  logic [3:0] in_raw_row_1 = '0;
  logic [3:0] in_raw_row_2 = '0;
  logic [3:0] in_raw_row_3 = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [4:0] out_current_key;
  logic [4:0] out_last_key;
  logic       out_press_event;
  logic       out_release_event;
  logic [15:0] out_press_total;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_debounce_scans = '0;

  // model state
  logic [7:0]                 threshold = mkde_pkg::THR_RESET;
  mkde_pkg::row_set_t         db_rows = '0;
  logic [7:0]                 miss_cnt [mkde_pkg::ROW_MAX];
  logic [mkde_pkg::KEY_W-1:0] held = mkde_pkg::NO_KEY;
  logic [mkde_pkg::KEY_W-1:0] recent = mkde_pkg::NO_KEY;
  logic [15:0]                presses = '0;

  mkde_pkg::result_t expected_scans [$];
  int      mismatch_count = 0;
  int      send_gap_pct = 0;
  int      stall_pct = 0;
  int      quiet_cycles = 0;

  matrix_keypad_debounce_encoder_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_raw_row_0       (in_raw_row_0),
    .in_raw_row_1       (in_raw_row_1),
    .in_raw_row_2       (in_raw_row_2),
    .in_raw_row_3       (in_raw_row_3),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_current_key    (out_current_key),
    .out_last_key       (out_last_key),
    .out_press_event    (out_press_event),
    .out_release_event  (out_release_event),
    .out_press_total    (out_press_total),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_debounce_scans (cfg_debounce_scans)
  );

  always #5 clk = ~clk;

  function automatic mkde_pkg::result_t debounce_and_encode(input mkde_pkg::row_set_t raw);
    mkde_pkg::result_t          res;
    logic [mkde_pkg::KEY_W-1:0] key;
    logic                       found;
    int                         r;
    int                         c;
    key = mkde_pkg::NO_KEY;
    found = 1'b0;
    for (r = 0; r < mkde_pkg::ROWS; r++) begin
      if ((raw[r] & mkde_pkg::COL_MASK) == db_rows[r]) begin
        miss_cnt[r] = 8'd0;
      end else begin
        miss_cnt[r] = miss_cnt[r] + 8'd1;
        if (miss_cnt[r] >= threshold) begin
          db_rows[r] = raw[r] & mkde_pkg::COL_MASK;
          miss_cnt[r] = 8'd0;
        end
      end
    end
    for (r = 0; r < mkde_pkg::ROWS; r++) begin
      for (c = 0; c < mkde_pkg::COLS; c++) begin
        if (!found && db_rows[r][c]) begin
          key = mkde_pkg::KEY_W'(r * mkde_pkg::COLS + c);
          found = 1'b1;
        end
      end
    end
    res.press_event = (key != mkde_pkg::NO_KEY) && (held == mkde_pkg::NO_KEY);
    res.release_event = (key == mkde_pkg::NO_KEY) && (held != mkde_pkg::NO_KEY);
    if (res.press_event) begin
      recent = key;
      presses = presses + 16'd1;
    end
    held = key;
    res.current_key = held;
    res.last_key = recent;
    res.press_total = presses;
    return res;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_scan(input mkde_pkg::row_set_t rows, input logic typed,
                           input mkde_pkg::result_t want);
    mkde_pkg::result_t pred;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_raw_row_0 <= rows[0];
    in_raw_row_1 <= rows[1];
    in_raw_row_2 <= rows[2];
    in_raw_row_3 <= rows[3];
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = debounce_and_encode(rows);
    expected_scans.push_back(typed ? want : pred);
  endtask

  task automatic wait_results_clear();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_scans.size() != 0);
  endtask

  task automatic set_threshold(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_debounce_scans <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    threshold = value;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    mkde_pkg::result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_scans.size() == 0) begin
        log_mismatch("result transaction with no scan outstanding");
      end else begin
        want = expected_scans.pop_front();
        if (out_current_key !== want.current_key)
          log_mismatch($sformatf("current_key got %0d want %0d",
                                 out_current_key, want.current_key));
        if (out_last_key !== want.last_key)
          log_mismatch($sformatf("last_key got %0d want %0d",
                                 out_last_key, want.last_key));
        if (out_press_event !== want.press_event)
          log_mismatch($sformatf("press_event got %0b want %0b",
                                 out_press_event, want.press_event));
        if (out_release_event !== want.release_event)
          log_mismatch($sformatf("release_event got %0b want %0b",
                                 out_release_event, want.release_event));
        if (out_press_total !== want.press_total)
          log_mismatch($sformatf("press_total got %0d want %0d",
                                 out_press_total, want.press_total));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("matrix_keypad_debounce_encoder_unit regression: fail");
      $finish;
    end
  end

  initial begin
    mkde_pkg::row_set_t target;
    mkde_pkg::row_set_t scan;
    int          ph;
    int          ch;
    int          sent;
    int          hold;
    int          i;
    logic [7:0]  thr;
    for (i = 0; i < mkde_pkg::ROW_MAX; i++) miss_cnt[i] = 8'd0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].is_cfg) begin
        wait_results_clear();
        set_threshold(DIRECTED[i].thr);
      end else begin
        send_scan(DIRECTED[i].rows, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 9;
          stall_pct = 71;
        end
        1: begin
          send_gap_pct = 71;
          stall_pct = 9;
        end
        default: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (ch = 0; ch < 4; ch++) begin
        wait_results_clear();
        case ($urandom_range(7))
          0: thr = 8'd0;
          1: thr = 8'd255;
          2: thr = 8'd1;
          default: thr = 8'($urandom_range(2, 10));
        endcase
        set_threshold(thr);
        sent = 0;
        while (sent < CHUNK_SCANS) begin
          target = '0;
          case ($urandom_range(9))
            0, 1, 2: target = '0;
            3, 4, 5, 6: target[$urandom_range(3)] = 4'b0001 << $urandom_range(3);
            7, 8: target = mkde_pkg::row_set_t'($urandom_range(16'hFFFF));
            default: target = '1;
          endcase
          hold = $urandom_range(1, (threshold > 8'd12 ? 12 : int'(threshold)) + 4);
          repeat (hold) begin
            scan = target;
            // occasional bounce on one row
            if ($urandom_range(9) == 0)
              scan[$urandom_range(3)] ^= 4'($urandom_range(1, 15));
            send_scan(scan, 1'b0, '0);
            sent++;
          end
        end
      end
    end

    wait_results_clear();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("matrix_keypad_debounce_encoder_unit regression: pass");
    end else begin
      $display("matrix_keypad_debounce_encoder_unit regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/mkde_pkg.sv
hdl/mkde_row.sv
hdl/mkde_encode.sv
hdl/matrix_keypad_debounce_encoder_unit.sv
tb/matrix_keypad_debounce_encoder_unit_tb.sv
